// ----- src/epda_pkg.sv -----
// Shared types and constants for the elite pool diversity admission block.
package epda_pkg;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EVAL,
		ST_DECIDE,
		ST_COPY,
		ST_EMIT
	} state_t;

	// Result outcome codes
	typedef enum logic [2:0] {
		OUT_NEAR     = 3'd0,
		OUT_APPEND   = 3'd1,
		OUT_REPLACE  = 3'd2,
		OUT_WEAK     = 3'd3,
		OUT_TOO_LONG = 3'd4
	} outcome_t;

	// Configuration port
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 7;
	localparam logic [CFG_IDX_BITS-1:0] CFG_ELITE_CAP = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_THRESHOLD = 2'd1;

	// Field widths
	localparam int CAP_BITS       = 4;
	localparam int THR_BITS       = 7;
	localparam int SCORE_BITS     = 48;
	localparam int OUTCOME_BITS   = 3;
	localparam int OUT_SLOT_BITS  = 3;
	localparam int OUT_COUNT_BITS = 4;

	localparam logic [CAP_BITS-1:0] CAP_RESET = 4'd4;
	localparam logic [THR_BITS-1:0] THR_RESET = 7'd2;

	// Datapath status seen by the sequencer
	typedef struct packed {
		logic accept;
		logic pos_ok;
		logic last;
		logic scan_done;
		logic eval_done;
		logic near;
		logic write_ok;
		logic copy_done;
		logic out_free;
	} seq_status_t;

	// One-hot phase flags driven by the sequencer
	typedef struct packed {
		logic idle;
		logic scan;
		logic eval;
		logic decide;
		logic copy;
		logic emit;
	} seq_ctrl_t;

endpackage

// ----- src/epda_ram.sv -----
// Simple dual-port RAM: one write port, one registered read port.
module epda_ram #(
	parameter int DEPTH = 64,
	parameter int AW    = 6,
	parameter int DW    = 12
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem_q [DEPTH];
	logic [DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- src/epda_seq.sv -----
// Phase sequencer for the admission datapath.
module epda_seq (
	input  logic                  clk,
	input  logic                  arst_n,
	input  epda_pkg::seq_status_t status,
	output epda_pkg::seq_ctrl_t   ctrl
);

	import epda_pkg::*;

	state_t st_q, st_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			st_q <= ST_IDLE;
		else
			st_q <= st_d;
	end

	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE: begin
				if (status.accept) begin
					if (status.pos_ok)
						st_d = ST_SCAN;
					else if (status.last)
						st_d = ST_EMIT;
				end
			end
			ST_SCAN: begin
				if (status.scan_done)
					st_d = status.last ? ST_EVAL : ST_IDLE;
			end
			ST_EVAL: begin
				if (status.eval_done)
					st_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				st_d = (!status.near && status.write_ok) ? ST_COPY : ST_EMIT;
			end
			ST_COPY: begin
				if (status.copy_done)
					st_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (status.out_free)
					st_d = ST_IDLE;
			end
			default: st_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl = '0;
		case (st_q)
			ST_IDLE:   ctrl.idle   = 1'b1;
			ST_SCAN:   ctrl.scan   = 1'b1;
			ST_EVAL:   ctrl.eval   = 1'b1;
			ST_DECIDE: ctrl.decide = 1'b1;
			ST_COPY:   ctrl.copy   = 1'b1;
			ST_EMIT:   ctrl.emit   = 1'b1;
			default:   ctrl.idle   = 1'b1;
		endcase
	end

endmodule

// ----- src/elite_pool_diversity_admission.sv -----
// Top level: elite pool admission by Hamming diversity, iterative datapath.
//
//  channel  dir  handshake            payload
//  s_*      in   s_tvalid / s_tready  s_tdata {score, exact_id}, s_tlast = last
//  m_*      out  m_tvalid / m_tready  m_tdata {pool_count, slot, outcome}
//  cfg_*    in   cfg_valid / cfg_ready cfg_index, cfg_data
//
// Each position request is accepted in idle, then scanned against every
// held elite (none with an empty pool); the elite-id RAM has one
// registered read port and the elites are compared one per cycle.
// A last position adds an evaluation pass over the held elites, a decision,
// a copy into the pool when it is written, and the output register load.
// An overlong position is not scanned; if last, it goes straight to emit.
// Reset: asynchronous, clears pool count, candidate state and config to
// defaults; no clearing pass. Output register lets the next request in while
// a result waits; only a new result stalls on a full output register.
module elite_pool_diversity_admission #(
	parameter int MAX_ELITES = 8,
	parameter int MAX_LEN    = 64,
	parameter int ID_BITS    = 12
) (
	input  logic clk,
	input  logic arst_n,

	// s_tdata fields, low bit up: exact_id[ID_BITS], score[48], zero pad
	input  logic [((ID_BITS+epda_pkg::SCORE_BITS+7)/8)*8-1:0] s_tdata,
	input  logic                                             s_tvalid,
	input  logic                                             s_tlast,
	output logic                                             s_tready,

	// m_tdata fields, low bit up: outcome[3], slot[3], pool_count[4], zero pad
	output logic [15:0] m_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,

	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [epda_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [epda_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

	import epda_pkg::*;

	localparam int AB = $clog2(MAX_LEN);                       // position in a row
	localparam int PW = $clog2(MAX_LEN + 1);                   // length / position
	localparam int XB = (MAX_ELITES > 1) ? $clog2(MAX_ELITES) : 1; // slot index
	localparam int EW = $clog2(MAX_ELITES + 1);                // pool count
	localparam int SW = (PW > EW) ? PW : EW;                   // shared step counter
	localparam int CW = (EW > CAP_BITS) ? EW : CAP_BITS;
	localparam int TW = (PW > THR_BITS) ? PW : THR_BITS;
	localparam int IDS_DEPTH = MAX_ELITES * (2 ** AB);
	localparam int IA = XB + AB;
	localparam int OUT_W = 16;

	seq_status_t status;
	seq_ctrl_t   ctrl;

	// Configuration
	logic [CAP_BITS-1:0] cap_q;
	logic [THR_BITS-1:0] thr_q;

	// Latched request payload
	logic [ID_BITS-1:0]           id_q;
	logic signed [SCORE_BITS-1:0] score_q;
	logic                         last_q;

	// Candidate progress
	logic [PW-1:0] pos_q;
	logic          overlong_q;
	logic [PW-1:0] mm_q [MAX_ELITES];

	// Pool
	logic [EW-1:0]                count_q;
	logic [PW-1:0]                len_q   [MAX_ELITES];
	logic signed [SCORE_BITS-1:0] escore_q [MAX_ELITES];

	// Shared step counter and read-pipeline tag
	logic [SW-1:0] step_q;
	logic          pend_s1;
	logic [SW-1:0] pend_idx_s1;

	// Evaluation results
	logic                         near_q;
	logic signed [SCORE_BITS-1:0] min_score_q;
	logic [XB-1:0]                min_idx_q;
	logic [XB-1:0]                slot_q;
	outcome_t                     outcome_q;
	logic [EW-1:0]                res_count_q;

	logic [OUT_W-1:0] m_tdata_q;
	logic             m_tvalid_q;

	logic s_accept;
	logic pos_ok;
	logic elite_left;
	logic copy_left;
	logic [XB-1:0] sel;
	logic [PW-1:0] span;
	logic [CW-1:0] cap_eff;
	logic room, stronger;
	logic hit;
	logic clear_cand;

	logic              ids_we, ids_re;
	logic [IA-1:0]     ids_waddr, ids_raddr;
	logic [ID_BITS-1:0] ids_rdata;
	logic              cb_we, cb_re;
	logic [ID_BITS-1:0] cb_rdata;

	assign s_tready  = ctrl.idle;
	assign cfg_ready = 1'b1;
	assign s_accept  = s_tvalid && s_tready;
	assign pos_ok    = pos_q < PW'(MAX_LEN);

	assign elite_left = step_q < SW'(count_q);
	assign copy_left  = step_q < SW'(pos_q);

	// One elite is looked at per cycle: the tagged one in scan, the step one in eval
	assign sel = ctrl.scan ? pend_idx_s1[XB-1:0] : step_q[XB-1:0];

	assign hit  = ctrl.scan && pend_s1 && (pos_q < len_q[sel]) && (ids_rdata != id_q);
	assign span = (len_q[sel] == pos_q) ? mm_q[sel] : pos_q;

	always_comb begin
		cap_eff = CW'(cap_q);
		if (cap_q == '0)
			cap_eff = CW'(1);
		else if (CW'(cap_q) > CW'(MAX_ELITES))
			cap_eff = CW'(MAX_ELITES);
	end

	assign room     = CW'(count_q) < cap_eff;
	assign stronger = score_q > min_score_q;

	assign status.accept    = s_accept;
	assign status.pos_ok    = pos_ok;
	assign status.last      = ctrl.idle ? s_tlast : last_q;
	assign status.scan_done = !elite_left && !pend_s1;
	assign status.eval_done = !elite_left;
	assign status.near      = near_q;
	assign status.write_ok  = room || stronger;
	assign status.copy_done = !copy_left && !pend_s1;
	assign status.out_free  = !m_tvalid_q || m_tready;

	// Candidate ends whenever a result is formed
	assign clear_cand = (ctrl.idle && s_accept && !pos_ok && s_tlast) ||
	                    (ctrl.decide && !(!near_q && (room || stronger))) ||
	                    (ctrl.copy && status.copy_done);

	// Stored elite ids: row per slot, read during scan, written during copy
	assign ids_re    = ctrl.scan && elite_left;
	assign ids_raddr = {step_q[XB-1:0], pos_q[AB-1:0]};
	assign ids_we    = ctrl.copy && pend_s1;
	assign ids_waddr = {slot_q, pend_idx_s1[AB-1:0]};

	epda_ram #(
		.DEPTH (IDS_DEPTH),
		.AW    (IA),
		.DW    (ID_BITS)
	) u_ids (
		.clk   (clk),
		.we    (ids_we),
		.waddr (ids_waddr),
		.wdata (cb_rdata),
		.re    (ids_re),
		.raddr (ids_raddr),
		.rdata (ids_rdata)
	);

	// Candidate buffer: written on each in-range request, read back during copy
	assign cb_we = ctrl.idle && s_accept && pos_ok;
	assign cb_re = ctrl.copy && copy_left;

	epda_ram #(
		.DEPTH (MAX_LEN),
		.AW    (AB),
		.DW    (ID_BITS)
	) u_cbuf (
		.clk   (clk),
		.we    (cb_we),
		.waddr (pos_q[AB-1:0]),
		.wdata (s_tdata[ID_BITS-1:0]),
		.re    (cb_re),
		.raddr (step_q[AB-1:0]),
		.rdata (cb_rdata)
	);

	epda_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctrl   (ctrl)
	);

	// Config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
			thr_q <= THR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_ELITE_CAP: cap_q <= cfg_data[CAP_BITS-1:0];
				CFG_THRESHOLD: thr_q <= cfg_data[THR_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Request payload
	always_ff @(posedge clk) begin
		if (s_accept) begin
			id_q    <= s_tdata[ID_BITS-1:0];
			score_q <= s_tdata[ID_BITS +: SCORE_BITS];
			last_q  <= s_tlast;
		end
	end

	// Step counter and read tag, shared by scan, eval and copy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= '0;
			pend_s1     <= 1'b0;
			pend_idx_s1 <= '0;
		end else begin
			if (ctrl.idle || ctrl.decide) begin
				step_q  <= '0;
				pend_s1 <= 1'b0;
			end else if (ctrl.scan || ctrl.copy) begin
				if (ctrl.scan ? elite_left : copy_left) begin
					step_q      <= step_q + SW'(1);
					pend_s1     <= 1'b1;
					pend_idx_s1 <= step_q;
				end else begin
					pend_s1 <= 1'b0;
					if (!pend_s1)
						step_q <= '0;
				end
			end else if (ctrl.eval && elite_left) begin
				step_q <= step_q + SW'(1);
			end
		end
	end

	// Candidate position, overflow flag, mismatch counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			overlong_q <= 1'b0;
			for (int i = 0; i < MAX_ELITES; i++)
				mm_q[i] <= '0;
		end else if (clear_cand) begin
			pos_q      <= '0;
			overlong_q <= 1'b0;
			for (int i = 0; i < MAX_ELITES; i++)
				mm_q[i] <= '0;
		end else begin
			if (ctrl.idle && s_accept && !pos_ok)
				overlong_q <= 1'b1;
			if (ctrl.scan && status.scan_done)
				pos_q <= pos_q + PW'(1);
			if (hit)
				mm_q[sel] <= mm_q[sel] + PW'(1);
		end
	end

	// Evaluation pass: any elite too close, and first lowest score
	always_ff @(posedge clk) begin
		if (ctrl.scan)
			near_q <= 1'b0;
		else if (ctrl.eval && elite_left) begin
			if (TW'(span) < TW'(thr_q))
				near_q <= 1'b1;
			if (step_q == '0 || escore_q[sel] < min_score_q) begin
				min_score_q <= escore_q[sel];
				min_idx_q   <= sel;
			end
		end
	end

	// Result fields
	always_ff @(posedge clk) begin
		if (ctrl.idle && s_accept && !pos_ok && s_tlast) begin
			outcome_q   <= OUT_TOO_LONG;
			slot_q      <= '0;
			res_count_q <= count_q;
		end else if (ctrl.decide) begin
			res_count_q <= count_q;
			if (near_q) begin
				outcome_q <= OUT_NEAR;
				slot_q    <= '0;
			end else if (room) begin
				outcome_q <= OUT_APPEND;
				slot_q    <= count_q[XB-1:0];
			end else if (stronger) begin
				outcome_q <= OUT_REPLACE;
				slot_q    <= min_idx_q;
			end else begin
				outcome_q <= OUT_WEAK;
				slot_q    <= '0;
			end
		end else if (ctrl.copy && status.copy_done) begin
			if (outcome_q == OUT_APPEND)
				res_count_q <= count_q + EW'(1);
		end
	end

	// Pool bookkeeping, committed at the end of the copy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			for (int i = 0; i < MAX_ELITES; i++)
				len_q[i] <= '0;
		end else if (ctrl.copy && status.copy_done) begin
			len_q[slot_q] <= pos_q;
			if (outcome_q == OUT_APPEND)
				count_q <= count_q + EW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.copy && status.copy_done)
			escore_q[slot_q] <= score_q;
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid_q <= 1'b0;
		else if (ctrl.emit && status.out_free)
			m_tvalid_q <= 1'b1;
		else if (m_tready)
			m_tvalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (ctrl.emit && status.out_free)
			m_tdata_q <= OUT_W'({OUT_COUNT_BITS'(res_count_q), OUT_SLOT_BITS'(slot_q),
			                     OUTCOME_BITS'(outcome_q)});
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

`ifndef NO_ASSERTIONS
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= EW'(MAX_ELITES))
		else $error("pool count above capacity");

	a_count_mono: assert property (@(posedge clk) disable iff (!arst_n)
		count_q >= $past(count_q))
		else $error("pool count decreased");

	a_overlong_pos: assert property (@(posedge clk) disable iff (!arst_n)
		overlong_q |-> pos_q == PW'(MAX_LEN))
		else $error("overlong flag with position short of max length");

	a_tag_phase: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> (ctrl.scan || ctrl.copy))
		else $error("read tag live outside scan or copy");

	a_emit_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(ctrl.emit))
		else $error("result shown without emit phase");
`endif

endmodule

// ----- tb/elite_pool_diversity_admission_test.sv -----
// Self-checking testbench for the elite pool diversity admission block.
`timescale 1ns / 1ps

module elite_pool_diversity_admission_test;
	import epda_pkg::*;

	// Block geometry, kept at the block's defaults
	localparam int POOL_DEPTH = 8;
	localparam int SEQ_MAX    = 64;
	localparam int ID_W       = 12;
	localparam int S_W        = ((ID_W + SCORE_BITS + 7) / 8) * 8;
	localparam int S_PAD      = S_W - ID_W - SCORE_BITS;

	// Run control
	localparam int RANDOM_ITEMS  = 360;
	localparam int PHASE_ITEMS   = 60;
	localparam int SETTLE_CYCLES = 200;
	localparam int STALL_CYCLES  = 400;      // long output hold-off
	localparam int CYCLE_LIMIT   = 600000;

	localparam logic signed [SCORE_BITS-1:0] SCORE_MAX = {1'b0, {(SCORE_BITS-1){1'b1}}};
	localparam logic signed [SCORE_BITS-1:0] SCORE_MIN = {1'b1, {(SCORE_BITS-1){1'b0}}};

	// One expected admission decision
	typedef struct {
		outcome_t        outcome;
		logic [2:0]      slot;
		logic [3:0]      count;
	} admission_t;

	logic clk = 1'b0;
	logic arst_n;

	logic [S_W-1:0]            s_tdata;   // exact_id[12], score[48], zero pad
	logic                      s_tvalid;
	logic                      s_tlast;
	logic                      s_tready;
	logic [15:0]               m_tdata;   // outcome[3], slot[3], pool_count[4], zero pad
	logic                      m_tvalid;
	logic                      m_tready;
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic [CFG_IDX_BITS-1:0]   cfg_index;
	logic [CFG_DATA_BITS-1:0]  cfg_data;

	elite_pool_diversity_admission #(
		.MAX_ELITES(POOL_DEPTH),
		.MAX_LEN   (SEQ_MAX),
		.ID_BITS   (ID_W)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tvalid (s_tvalid),
		.s_tlast  (s_tlast),
		.s_tready (s_tready),
		.m_tdata  (m_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Pool predictor: its own copy of the elites, the candidate in flight
	// and the two registers.
	// ------------------------------------------------------------------
	logic [ID_W-1:0]              pool_ids [POOL_DEPTH][SEQ_MAX];
	int unsigned                  pool_len [POOL_DEPTH];
	logic signed [SCORE_BITS-1:0] pool_score [POOL_DEPTH];
	int unsigned                  held;
	int unsigned                  diff_count [POOL_DEPTH];
	logic [ID_W-1:0]              cand_ids [SEQ_MAX];
	int unsigned                  cand_pos;
	bit                           cand_over;
	logic [CAP_BITS-1:0]          cap_reg;
	logic [THR_BITS-1:0]          thr_reg;

	admission_t admission_q [$];

	function automatic void reset_pool_model();
		int i;
		held      = 0;
		cand_pos  = 0;
		cand_over = 1'b0;
		cap_reg   = CAP_RESET;
		thr_reg   = THR_RESET;
		for (i = 0; i < POOL_DEPTH; i++) begin
			pool_len[i]   = 0;
			pool_score[i] = '0;
			diff_count[i] = 0;
		end
	endfunction

	// Advance the model by one position request; a last position yields a decision.
	function automatic void predict_position(input logic [ID_W-1:0] id,
			input logic signed [SCORE_BITS-1:0] sc, input logic lst);
		int unsigned n, cap_eff, span, weakest;
		bit          is_near, do_write;
		admission_t  res;
		int          i;
		if (cand_pos < SEQ_MAX) begin
			cand_ids[cand_pos] = id;
			for (i = 0; i < held; i++)
				if (cand_pos < pool_len[i] && pool_ids[i][cand_pos] != id)
					diff_count[i]++;
			cand_pos++;
		end else begin
			cand_over = 1'b1;
		end
		if (!lst)
			return;

		n = cand_pos;
		// cap zero acts as one, above the pool depth it saturates
		cap_eff = (cap_reg == 0) ? 1 : (cap_reg > POOL_DEPTH) ? POOL_DEPTH : cap_reg;
		res.slot = '0;
		do_write = 1'b0;
		if (cand_over) begin
			res.outcome = OUT_TOO_LONG;
		end else begin
			is_near = 1'b0;
			for (i = 0; i < held; i++) begin
				// differing lengths count as the full candidate length
				span = (pool_len[i] == n) ? diff_count[i] : n;
				if (span < thr_reg)
					is_near = 1'b1;
			end
			if (is_near) begin
				res.outcome = OUT_NEAR;
			end else if (held < cap_eff) begin
				res.outcome = OUT_APPEND;
				res.slot    = 3'(held);
				held++;
				do_write    = 1'b1;
			end else begin
				// first lowest score wins the tie; covers a cap lowered under the count
				weakest = 0;
				for (i = 1; i < held; i++)
					if (pool_score[i] < pool_score[weakest])
						weakest = i;
				if (sc > pool_score[weakest]) begin
					res.outcome = OUT_REPLACE;
					res.slot    = 3'(weakest);
					do_write    = 1'b1;
				end else begin
					res.outcome = OUT_WEAK;
				end
			end
		end
		if (do_write) begin
			for (i = 0; i < n; i++)
				pool_ids[res.slot][i] = cand_ids[i];
			pool_len[res.slot]   = n;
			pool_score[res.slot] = sc;
		end
		res.count = 4'(held);
		admission_q.insert(admission_q.size(), res);

		// every candidate end clears the running state
		cand_pos  = 0;
		cand_over = 1'b0;
		for (i = 0; i < POOL_DEPTH; i++)
			diff_count[i] = 0;
	endfunction

	// ------------------------------------------------------------------
	// Result checking
	// ------------------------------------------------------------------
	int errors = 0;
	int outcome_seen [5];
	int positions_sent = 0;
	int candidates_sent = 0;

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		errors++;
	endtask

	always @(posedge clk) begin
		admission_t want;
		if (arst_n === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1) begin
			if (admission_q.size() == 0) begin
				report_mismatch($sformatf("result %h with no decision pending", m_tdata));
			end else begin
				want = admission_q.pop_front();
				outcome_seen[int'(want.outcome)]++;
				if (m_tdata[2:0] !== want.outcome)
					report_mismatch($sformatf("outcome %0d, wanted %0d",
						m_tdata[2:0], want.outcome));
				if (m_tdata[5:3] !== want.slot)
					report_mismatch($sformatf("slot %0d, wanted %0d",
						m_tdata[5:3], want.slot));
				if (m_tdata[9:6] !== want.count)
					report_mismatch($sformatf("pool_count %0d, wanted %0d",
						m_tdata[9:6], want.count));
			end
		end
	end

	// ------------------------------------------------------------------
	// Receiver: random ready at ready_pct, or a counted hold-off
	// ------------------------------------------------------------------
	int ready_pct = 100;
	int hold_req  = 0;     // bumped by a test to ask for a long hold-off
	int hold_seen = 0;
	int hold_left = 0;

	always @(negedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_left = STALL_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(1, 100) <= ready_pct);
		end
	end

	// ------------------------------------------------------------------
	// Sender: bursts of requests with random gaps in between
	// ------------------------------------------------------------------
	int burst_left = 0;
	int gap_max = 0;

	logic [ID_W-1:0] seq_buf [128];
	int              seq_len;

	function automatic logic signed [SCORE_BITS-1:0] random_score();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[SCORE_BITS-1:0];
	endfunction

	task automatic send_position(input logic [ID_W-1:0] id,
			input logic signed [SCORE_BITS-1:0] sc, input logic lst);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
			if (gap > 0) begin
				@(negedge clk);
				s_tvalid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= {{S_PAD{1'b0}}, sc, id};
		s_tlast  <= lst;
		do @(posedge clk); while (s_tready !== 1'b1);
		predict_position(id, sc, lst);
		positions_sent++;
	endtask

	// Send seq_buf as one candidate; score only matters on the last position.
	task automatic send_candidate(input logic signed [SCORE_BITS-1:0] sc);
		bit at_end;
		for (int p = 0; p < seq_len; p++) begin
			at_end = (p == seq_len - 1);
			send_position(seq_buf[p], at_end ? sc : random_score(), at_end);
		end
		candidates_sent++;
	endtask

	function automatic void fill_random(input int len, input bit narrow);
		seq_len = len;
		for (int p = 0; p < len; p++)
			seq_buf[p] = narrow ? ID_W'($urandom_range(0, 3)) : ID_W'($urandom_range(0, 4095));
	endfunction

	// Copy a held elite and flip a few positions to land near it.
	function automatic void fill_from_elite(input int slot, input int edits);
		seq_len = pool_len[slot];
		for (int p = 0; p < seq_len; p++)
			seq_buf[p] = pool_ids[slot][p];
		repeat (edits)
			seq_buf[$urandom_range(0, seq_len - 1)] = ID_W'($urandom_range(0, 4095));
	endfunction

	task automatic write_config(input logic [CFG_IDX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		if (idx == CFG_ELITE_CAP)
			cap_reg = val[CAP_BITS-1:0];
		else if (idx == CFG_THRESHOLD)
			thr_reg = val[THR_BITS-1:0];
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Stop offering, wait for every decision, then let any trailing request finish.
	task automatic settle_block();
		@(negedge clk);
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (admission_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Directed tests
	// ------------------------------------------------------------------

	// Reset registers: empty pool appends, a one-off id is a near duplicate.
	task automatic test_default_admission();
		seq_len = 1; seq_buf[0] = '0;
		send_candidate(SCORE_MAX);
		seq_len = 2; seq_buf[0] = '1; seq_buf[1] = '0;
		send_candidate(SCORE_MIN);
		seq_len = 1; seq_buf[0] = ID_W'(1);
		send_candidate('0);
		settle_block();
	endtask

	// Threshold zero admits everything, the top of the field rejects everything.
	task automatic test_threshold_extremes();
		write_config(CFG_THRESHOLD, 7'd0);
		seq_len = 1; seq_buf[0] = ID_W'(1);
		send_candidate('0);
		settle_block();
		write_config(CFG_THRESHOLD, 7'h7F);
		seq_len = 1; seq_buf[0] = ID_W'(12'hABC);
		send_candidate(SCORE_MAX);
		settle_block();
	endtask

	// Longest candidate that fits, then one position too many.
	task automatic test_length_limit();
		write_config(CFG_THRESHOLD, 7'd64);
		fill_random(SEQ_MAX, 1'b0);
		send_candidate(48'sd1);
		fill_random(SEQ_MAX + 1, 1'b0);
		send_candidate(SCORE_MAX);
		settle_block();
	endtask

	// Cap zero (upper data bits set), cap past the depth, cap under the count.
	task automatic test_cap_limits();
		write_config(CFG_THRESHOLD, 7'd0);
		write_config(CFG_ELITE_CAP, 7'h10);
		seq_len = 1; seq_buf[0] = ID_W'(5);
		send_candidate(SCORE_MIN);                 // ties the weakest: not stronger
		seq_buf[0] = ID_W'(6);
		send_candidate(-48'sd5);                   // beats the weakest
		settle_block();
		write_config(CFG_ELITE_CAP, 7'h7F);
		for (int k = 0; k < 5; k++) begin
			seq_buf[0] = ID_W'(k + 16);
			send_candidate(48'sd10 + k);
		end
		settle_block();
		write_config(CFG_ELITE_CAP, 7'd2);
		seq_buf[0] = ID_W'(7);
		send_candidate('0);
		settle_block();
	endtask

	// Long output hold-off fills the block and stalls its input, then a full drain.
	task automatic test_output_stall();
		write_config(CFG_ELITE_CAP, 7'd8);
		ready_pct = 100;
		gap_max   = 0;
		@(posedge clk);
		hold_req++;
		for (int k = 0; k < 12; k++) begin
			fill_random($urandom_range(1, 3), 1'b0);
			send_candidate(random_score());
		end
		settle_block();
	endtask

	// ------------------------------------------------------------------
	// Random phases: new registers, receiver and sender profile each phase
	// ------------------------------------------------------------------
	task automatic test_random_admission();
		int start, phase_end, phase, pick, long_left;
		logic [CFG_DATA_BITS-1:0] cap_val, thr_val;
		logic signed [SCORE_BITS-1:0] sc;
		start     = positions_sent;
		phase     = 0;
		long_left = 2;
		while (positions_sent - start < RANDOM_ITEMS) begin
			settle_block();
			pick = $urandom_range(0, 9);
			cap_val = (pick == 0) ? 7'd0 : (pick == 1) ? 7'($urandom_range(9, 15))
				: 7'($urandom_range(1, 8));
			pick = $urandom_range(0, 9);
			thr_val = (pick == 0) ? 7'd64 : (pick == 1) ? 7'd0 : 7'($urandom_range(1, 4));
			write_config(CFG_ELITE_CAP, cap_val);
			write_config(CFG_THRESHOLD, thr_val);
			ready_pct = (phase % 3 == 0) ? 100 : (phase % 3 == 1) ? 60 : 25;
			gap_max   = (phase % 4 == 0) ? 0 : (phase % 4 == 1) ? 4 : (phase % 4 == 2) ? 15 : 1;
			phase_end = positions_sent + PHASE_ITEMS;
			while (positions_sent < phase_end) begin
				pick = $urandom_range(0, 99);
				if (pick < 2 && long_left > 0) begin
					long_left--;
					fill_random(SEQ_MAX, 1'b0);
				end else if (pick < 5) begin
					fill_random($urandom_range(SEQ_MAX + 1, SEQ_MAX + 4), 1'b1);
				end else if (pick < 60 && held > 0) begin
					fill_from_elite($urandom_range(0, held - 1), $urandom_range(0, 3));
					if ($urandom_range(0, 4) == 0)
						fill_random($urandom_range(1, 8), 1'b1);
				end else begin
					fill_random($urandom_range(1, 8), 1'($urandom_range(0, 1)));
				end
				// narrow scores give ties, wide ones exercise every bit
				sc = ($urandom_range(0, 1) == 0) ? SCORE_BITS'($signed($urandom_range(0, 14)) - 7)
					: random_score();
				send_candidate(sc);
			end
			phase++;
		end
		settle_block();
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tlast   = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_ELITE_CAP;
		cfg_data  = '0;
		reset_pool_model();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_default_admission();
		test_threshold_extremes();
		test_length_limit();
		test_cap_limits();
		test_output_stall();
		test_random_admission();

		$display("covered %0d position requests in %0d candidates",
			positions_sent, candidates_sent);
		$display("decisions: near %0d, appended %0d, replaced %0d, not stronger %0d, too long %0d",
			outcome_seen[0], outcome_seen[1], outcome_seen[2], outcome_seen[3], outcome_seen[4]);
		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	// Watchdog
	initial begin
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles, %0d decisions pending", cycles, admission_q.size());
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ----- elite_pool_diversity_admission.f -----
src/epda_pkg.sv
src/epda_ram.sv
src/epda_seq.sv
src/elite_pool_diversity_admission.sv
tb/elite_pool_diversity_admission_test.sv
